@@ hw/rtl/gla_pkg.sv @@
// Shared types, codes and display band table for the gas level alarm controller.
package gla_pkg;

  localparam logic [1:0] LVL_SAFE   = 2'd0;
  localparam logic [1:0] LVL_WARN   = 2'd1;
  localparam logic [1:0] LVL_DANGER = 2'd2;

  localparam logic [2:0] AUD_NONE         = 3'd0;
  localparam logic [2:0] AUD_SILENCE      = 3'd1;
  localparam logic [2:0] AUD_VOICE        = 3'd2;
  localparam logic [2:0] AUD_BEEP         = 3'd3;
  localparam logic [2:0] AUD_TRIPLE       = 3'd4;
  localparam logic [2:0] AUD_TRIPLE_VOICE = 3'd5;

  localparam logic [1:0] FAN_KEEP  = 2'd0;
  localparam logic [1:0] FAN_OPEN  = 2'd1;
  localparam logic [1:0] FAN_CLOSE = 2'd2;

  localparam logic [2:0] REG_WARN_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_DANGER_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_BEEP_DELAY       = 3'd2;
  localparam logic [2:0] REG_REPLY_ADDRESS    = 3'd3;
  localparam logic [2:0] REG_REPLY_LENGTH     = 3'd4;

  localparam logic [15:0] RST_WARN_THRESHOLD   = 16'd21;
  localparam logic [15:0] RST_DANGER_THRESHOLD = 16'd41;
  localparam logic [7:0]  RST_BEEP_DELAY       = 8'd20;
  localparam logic [7:0]  RST_REPLY_ADDRESS    = 8'h01;
  localparam logic [4:0]  RST_REPLY_LENGTH     = 5'd7;

  localparam int NUM_BAND_TOPS = 8;
  localparam logic [15:0] BAND_TOP [NUM_BAND_TOPS] = '{
    16'd12, 16'd16, 16'd20, 16'd28, 16'd35, 16'd40, 16'd48, 16'd100
  };

  typedef struct packed {
    logic [15:0] warn_threshold;
    logic [15:0] danger_threshold;
    logic [7:0]  beep_delay_polls;
    logic [7:0]  reply_address;
    logic [4:0]  reply_length;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  rx_count;
    logic [7:0]  rx_address;
    logic [15:0] ppm_value;
    logic        power_on;
  } item_t;

  typedef struct packed {
    logic [15:0] latched_ppm;
    logic [3:0]  band;
    logic [1:0]  active_level;
    logic [1:0]  prior_level;
    logic [7:0]  poll_count;
  } alarm_state_t;

  typedef struct packed {
    logic [2:0]  audio_cmd;
    logic [1:0]  fan_action;
    logic [3:0]  display_band;
    logic [15:0] ppm_now;
  } result_t;

  // First band whose upper bound covers the reading; above all bounds is band 8.
  function automatic logic [3:0] band_of(input logic [15:0] ppm);
    logic [3:0] b;
    b = 4'd8;
    for (int i = NUM_BAND_TOPS - 1; i >= 0; i--) begin
      if (ppm <= BAND_TOP[i]) b = 4'(i);
    end
    return b;
  endfunction

endpackage

@@ hw/rtl/gla_cfg_regs.sv @@
// Configuration register file written through a plain write port.
module gla_cfg_regs
  import gla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold   <= RST_WARN_THRESHOLD;
      cfg.danger_threshold <= RST_DANGER_THRESHOLD;
      cfg.beep_delay_polls <= RST_BEEP_DELAY;
      cfg.reply_address    <= RST_REPLY_ADDRESS;
      cfg.reply_length     <= RST_REPLY_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARN_THRESHOLD:   cfg.warn_threshold   <= cfg_data;
        REG_DANGER_THRESHOLD: cfg.danger_threshold <= cfg_data;
        REG_BEEP_DELAY:       cfg.beep_delay_polls <= cfg_data[7:0];
        REG_REPLY_ADDRESS:    cfg.reply_address    <= cfg_data[7:0];
        REG_REPLY_LENGTH:     cfg.reply_length     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/gla_alarm.sv @@
// Per-poll decision logic: reading latch, band lookup and the alarm level machine.
module gla_alarm
  import gla_pkg::*;
(
  input  item_t        item,
  input  cfg_t         cfg,
  input  alarm_state_t st,
  output alarm_state_t st_next,
  output result_t      res
);

  logic [15:0] ppm;
  logic [3:0]  band;
  logic [1:0]  act;
  logic [1:0]  pri;
  logic [7:0]  cnt;
  logic [2:0]  audio;
  logic [1:0]  fan;

  always_comb begin
    ppm   = st.latched_ppm;
    band  = st.band;
    act   = st.active_level;
    pri   = st.prior_level;
    cnt   = st.poll_count;
    audio = AUD_NONE;
    fan   = FAN_KEEP;

    if (item.rx_count == cfg.reply_length && item.rx_address == cfg.reply_address) begin
      ppm  = item.ppm_value;
      band = band_of(item.ppm_value);
    end

    if (!item.power_on) begin
      cnt   = 8'd0;
      audio = AUD_SILENCE;
      fan   = FAN_CLOSE;
    end else if (ppm >= cfg.danger_threshold) begin
      if (act < LVL_DANGER) begin
        cnt   = 8'd0;
        audio = (act == LVL_SAFE && pri == LVL_SAFE) ? AUD_TRIPLE_VOICE : AUD_TRIPLE;
        act   = LVL_DANGER;
        pri   = LVL_DANGER;
        fan   = FAN_OPEN;
      end
    end else if (ppm >= cfg.warn_threshold) begin
      // the checks below chain: each sees the levels left by the one before
      if (act == LVL_SAFE && pri == LVL_SAFE) begin
        act   = LVL_WARN;
        cnt   = 8'd0;
        audio = AUD_VOICE;
        fan   = FAN_OPEN;
      end
      if (act == LVL_WARN && pri == LVL_SAFE) begin
        if (cnt >= cfg.beep_delay_polls) begin
          cnt = 8'd0;
          if (audio == AUD_NONE) audio = AUD_BEEP;
          pri = LVL_WARN;
        end else begin
          cnt = cnt + 8'd1;
        end
      end
      if (act == LVL_DANGER && pri == LVL_DANGER) begin
        act   = LVL_WARN;
        audio = AUD_BEEP;
        pri   = LVL_WARN;
      end
      if (act == LVL_WARN && pri == LVL_DANGER) begin
        pri = LVL_WARN;
      end
    end else begin
      if (act > LVL_SAFE) begin
        cnt   = 8'd0;
        act   = LVL_SAFE;
        pri   = LVL_SAFE;
        audio = AUD_SILENCE;
        fan   = FAN_CLOSE;
      end
    end

    st_next.latched_ppm  = ppm;
    st_next.band         = band;
    st_next.active_level = act;
    st_next.prior_level  = pri;
    st_next.poll_count   = cnt;

    res.audio_cmd    = audio;
    res.fan_action   = fan;
    res.display_band = band;
    res.ppm_now      = ppm;
  end

endmodule

@@ hw/rtl/gas_level_alarm_controller.sv @@
// Top level of the gas level alarm controller: input register, alarm state, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sensor poll per item:
//   rx_count, rx_address, ppm_value, power_on. Output channel
//   (out_valid / out_stall) returns exactly one result item per poll:
//   audio_cmd, fan_action, display_band, ppm_now.
//   An item is taken at a clock edge where valid is high and stall is low.
//   The input register loads at the input accept edge; the result register
//   loads from it once the output register is empty or its item is taken.
//   Throughput: one item per cycle while the output is not stalled; the alarm
//   state is read and updated combinationally between the two registers.
//   When the receiver stalls, the result register holds its item and the input
//   register can still take one more item; in_stall rises only when both are
//   full and the output is stalled.
//   Configuration (cfg_we, cfg_index, cfg_data) writes one register per edge;
//   write only while no item is in flight. Unknown indexes are ignored.
//   Reset (rst, synchronous): both registers empty, thresholds 21 and 41,
//   beep delay 20 polls, address 0x01, length 7, alarm state safe, ppm 0.
module gas_level_alarm_controller
  import gla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  rx_count,
  input  logic [7:0]  rx_address,
  input  logic [15:0] ppm_value,
  input  logic        power_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  audio_cmd,
  output logic [1:0]  fan_action,
  output logic [3:0]  display_band,
  output logic [15:0] ppm_now
);

  cfg_t         cfg;
  item_t        item_reg;
  logic         item_valid;
  alarm_state_t state;
  alarm_state_t state_next;
  result_t      res_next;
  result_t      res_reg;
  logic         out_free;
  logic         advance;
  logic         in_fire;

  gla_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gla_alarm u_alarm (
    .item    (item_reg),
    .cfg     (cfg),
    .st      (state),
    .st_next (state_next),
    .res     (res_next)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_fire) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_reg.rx_count   <= rx_count;
      item_reg.rx_address <= rx_address;
      item_reg.ppm_value  <= ppm_value;
      item_reg.power_on   <= power_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_next;
    end
  end

  assign audio_cmd    = res_reg.audio_cmd;
  assign fan_action   = res_reg.fan_action;
  assign display_band = res_reg.display_band;
  assign ppm_now      = res_reg.ppm_now;

  // backpressure only when a held item sits in the input register
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("in_stall without a held item");

  a_level_legal: assert property (@(posedge clk) disable iff (rst)
    state.active_level != 2'd3 && state.prior_level != 2'd3)
    else $error("alarm level out of range");

  a_silence_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && audio_cmd == AUD_SILENCE |-> fan_action == FAN_CLOSE)
    else $error("silence without fan close");

  a_open_with_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && fan_action == FAN_OPEN |->
      audio_cmd == AUD_VOICE || audio_cmd == AUD_TRIPLE || audio_cmd == AUD_TRIPLE_VOICE)
    else $error("fan open without alarm");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("alarm state changed without an item");

endmodule

@@ tb/gas_level_alarm_controller_test.sv @@
// Self-checking testbench for the gas level alarm controller: poll driver, result monitor, alarm predictor.
module gas_level_alarm_controller_test;
  import gla_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_WARN_THRESHOLD;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  rx_count = 5'd0;
  logic [7:0]  rx_address = 8'd0;
  logic [15:0] ppm_value = 16'd0;
  logic        power_on = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  audio_cmd;
  logic [1:0]  fan_action;
  logic [3:0]  display_band;
  logic [15:0] ppm_now;

  // polls waiting to be driven, and predicted results in order
  item_t   pending_polls[$];
  result_t results_due[$];

  // predictor copy of the registers and alarm state
  cfg_t        regs;
  logic [15:0] ppm_held;
  logic [3:0]  band_held;
  logic [1:0]  lvl_now;
  logic [1:0]  lvl_prev;
  logic [7:0]  polls;

  int errors = 0;
  bit steady = 1'b0;

  gas_level_alarm_controller uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_count(rx_count), .rx_address(rx_address), .ppm_value(ppm_value), .power_on(power_on),
    .out_valid(out_valid), .out_stall(out_stall),
    .audio_cmd(audio_cmd), .fan_action(fan_action),
    .display_band(display_band), .ppm_now(ppm_now)
  );

  always #10 clk = ~clk;

  function automatic logic [3:0] band_for(logic [15:0] ppm);
    for (int k = 0; k < NUM_BAND_TOPS; k++) begin
      if (ppm <= BAND_TOP[k]) return 4'(k);
    end
    return 4'd8;
  endfunction

  function automatic result_t next_alarm(item_t p);
    result_t r;
    r.audio_cmd = AUD_NONE;
    r.fan_action = FAN_KEEP;
    if (p.rx_count == regs.reply_length && p.rx_address == regs.reply_address) begin
      ppm_held = p.ppm_value;
      band_held = band_for(p.ppm_value);
    end
    if (!p.power_on) begin
      polls = 8'd0;
      r.audio_cmd = AUD_SILENCE;
      r.fan_action = FAN_CLOSE;
    end else if (ppm_held >= regs.danger_threshold) begin
      if (lvl_now != LVL_DANGER) begin
        polls = 8'd0;
        r.audio_cmd = (lvl_now == LVL_SAFE && lvl_prev == LVL_SAFE) ? AUD_TRIPLE_VOICE
                                                                     : AUD_TRIPLE;
        lvl_now = LVL_DANGER;
        lvl_prev = LVL_DANGER;
        r.fan_action = FAN_OPEN;
      end
    end else if (ppm_held >= regs.warn_threshold) begin
      if (lvl_now == LVL_SAFE && lvl_prev == LVL_SAFE) begin
        lvl_now = LVL_WARN;
        polls = 8'd0;
        r.audio_cmd = AUD_VOICE;
        r.fan_action = FAN_OPEN;
      end
      // follow-up beep; with zero delay the voice command wins on the entry poll
      if (lvl_now == LVL_WARN && lvl_prev == LVL_SAFE) begin
        if (polls >= regs.beep_delay_polls) begin
          polls = 8'd0;
          if (r.audio_cmd == AUD_NONE) r.audio_cmd = AUD_BEEP;
          lvl_prev = LVL_WARN;
        end else begin
          polls = polls + 8'd1;
        end
      end
      if (lvl_now == LVL_DANGER && lvl_prev == LVL_DANGER) begin
        lvl_now = LVL_WARN;
        r.audio_cmd = AUD_BEEP;
        lvl_prev = LVL_WARN;
      end
      if (lvl_now == LVL_WARN && lvl_prev == LVL_DANGER) lvl_prev = LVL_WARN;
    end else if (lvl_now != LVL_SAFE) begin
      polls = 8'd0;
      lvl_now = LVL_SAFE;
      lvl_prev = LVL_SAFE;
      r.audio_cmd = AUD_SILENCE;
      r.fan_action = FAN_CLOSE;
    end
    r.display_band = band_held;
    r.ppm_now = ppm_held;
    return r;
  endfunction

  // zone 0 below both thresholds, 1 warning band, 2 danger, 3 threshold edges, 4 band edges
  function automatic logic [15:0] pick_ppm(int zone);
    int w;
    int d;
    int lo;
    w = regs.warn_threshold;
    d = regs.danger_threshold;
    lo = (w < d) ? w : d;
    case (zone)
      0: if (lo > 0) return 16'($urandom_range(lo - 1, 0));
      1: if (w < d) return 16'($urandom_range(d - 1, w));
      2: return 16'($urandom_range(65535, d));
      3: begin
        case ($urandom_range(3))
          0: return 16'(w - 1);
          1: return 16'(w);
          2: return 16'(d - 1);
          default: return 16'(d);
        endcase
      end
      4: return BAND_TOP[$urandom_range(NUM_BAND_TOPS - 1)] + 16'($urandom_range(1));
      default: ;
    endcase
    return 16'($urandom);
  endfunction

  // a reply that matches the current length and address, or one broken in count or address
  function automatic item_t make_poll(bit match, logic [15:0] ppm, bit pwr);
    item_t p;
    p.rx_count = regs.reply_length;
    p.rx_address = regs.reply_address;
    p.ppm_value = ppm;
    p.power_on = pwr;
    if (!match) begin
      case ($urandom_range(2))
        0: p.rx_count = 5'((regs.reply_length + $urandom_range(16, 1)) % 17);
        1: p.rx_address = regs.reply_address ^ 8'($urandom_range(255, 1));
        default: begin
          p.rx_count = 5'((regs.reply_length + $urandom_range(16, 1)) % 17);
          p.rx_address = regs.reply_address ^ 8'($urandom_range(255, 1));
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_poll(bit match, logic [15:0] ppm, bit pwr);
    pending_polls.push_back(make_poll(match, ppm, pwr));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_polls.size() != 0 || in_valid || results_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WARN_THRESHOLD:   regs.warn_threshold = val;
      REG_DANGER_THRESHOLD: regs.danger_threshold = val;
      REG_BEEP_DELAY:       regs.beep_delay_polls = val[7:0];
      REG_REPLY_ADDRESS:    regs.reply_address = val[7:0];
      REG_REPLY_LENGTH:     regs.reply_length = val[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] warn, logic [15:0] danger, logic [7:0] beep_delay,
                           logic [7:0] addr, logic [4:0] nbytes);
    write_reg(REG_WARN_THRESHOLD, warn);
    write_reg(REG_DANGER_THRESHOLD, danger);
    write_reg(REG_BEEP_DELAY, {8'd0, beep_delay});
    write_reg(REG_REPLY_ADDRESS, {8'd0, addr});
    write_reg(REG_REPLY_LENGTH, {11'd0, nbytes});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ppm stays in one zone for a run of polls so the alarm machine can walk its levels;
  // calm keeps the reading below 65535 with power up for long warning stretches
  task automatic run_phase(int n, int off_pct, int bad_pct, bit calm);
    int zone;
    int run;
    logic [15:0] ppm;
    zone = 0;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        zone = $urandom_range(5);
        run = $urandom_range(30, 1);
      end
      run--;
      ppm = calm ? 16'($urandom_range(65534)) : pick_ppm(zone);
      send_poll($urandom_range(99) >= bad_pct, ppm, calm || $urandom_range(99) >= off_pct);
    end
    wait_idle();
  endtask

  // poll driver
  always @(posedge clk) begin
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        results_due.push_back(next_alarm(item_t'({rx_count, rx_address, ppm_value, power_on})));
      if (pending_polls.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        nxt = pending_polls.pop_front();
        in_valid <= 1'b1;
        rx_count <= nxt.rx_count;
        rx_address <= nxt.rx_address;
        ppm_value <= nxt.ppm_value;
        power_on <= nxt.power_on;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result with none expected: audio_cmd %0d fan_action %0d band %0d ppm %0d",
                 audio_cmd, fan_action, display_band, ppm_now);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (audio_cmd !== want.audio_cmd) begin
            $error("audio_cmd: expected %0d, got %0d", want.audio_cmd, audio_cmd);
            errors++;
          end
          if (fan_action !== want.fan_action) begin
            $error("fan_action: expected %0d, got %0d", want.fan_action, fan_action);
            errors++;
          end
          if (display_band !== want.display_band) begin
            $error("display_band: expected %0d, got %0d", want.display_band, display_band);
            errors++;
          end
          if (ppm_now !== want.ppm_now) begin
            $error("ppm_now: expected %0d, got %0d", want.ppm_now, ppm_now);
            errors++;
          end
        end
      end
      out_stall <= !steady && $urandom_range(99) < 31;
    end
  end

  initial begin
    int w;
    regs = '{RST_WARN_THRESHOLD, RST_DANGER_THRESHOLD, RST_BEEP_DELAY,
             RST_REPLY_ADDRESS, RST_REPLY_LENGTH};
    ppm_held = 16'd0;
    band_held = 4'd0;
    lvl_now = LVL_SAFE;
    lvl_prev = LVL_SAFE;
    polls = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: band edges, broken replies, every level change, power off
    send_poll(1, 16'd0, 1);
    send_poll(1, 16'd12, 1);
    send_poll(1, 16'd13, 1);
    send_poll(1, 16'd17, 1);
    send_poll(1, 16'd20, 1);
    send_poll(1, 16'd21, 1);
    send_poll(0, 16'hFFFF, 1);
    send_poll(1, 16'd40, 1);
    send_poll(1, 16'd41, 1);
    send_poll(1, 16'd49, 1);
    send_poll(1, 16'd101, 1);
    send_poll(1, 16'd30, 1);
    send_poll(1, 16'hFFFF, 0);
    send_poll(1, 16'd0, 1);
    send_poll(1, 16'hFFFF, 1);
    send_poll(1, 16'd0, 1);
    wait_idle();

    // zero beep delay: voice on warning entry, beep swallowed
    configure(16'd5, 16'hFFFF, 8'd0, 8'hFF, 5'd16);
    send_poll(1, 16'd5, 1);
    send_poll(1, 16'd6, 1);
    send_poll(0, 16'd3, 1);
    send_poll(1, 16'd4, 1);
    wait_idle();

    // crossed thresholds: danger wins at or above its threshold
    configure(16'd60, 16'd30, 8'd0, 8'h00, 5'd0);
    send_poll(1, 16'd29, 1);
    send_poll(1, 16'd30, 1);
    send_poll(1, 16'd70, 1);
    send_poll(1, 16'hFFFF, 1);
    wait_idle();

    w = $urandom_range(60, 15);
    configure(16'(w), 16'(w + $urandom_range(60, 1)), 8'($urandom_range(5)),
              8'($urandom), 5'($urandom_range(16)));
    run_phase(90, 5, 15, 0);

    w = $urandom_range(200, 20);
    configure(16'(w), 16'($urandom_range(w - 1, 0)), 8'($urandom_range(8)),
              8'($urandom), 5'($urandom_range(16)));
    run_phase(60, 5, 15, 0);

    steady = 1'b1;
    w = $urandom_range(40, 15);
    configure(16'(w), 16'(w + $urandom_range(30, 1)), 8'($urandom_range(3)),
              8'($urandom), 5'($urandom_range(16)));
    run_phase(70, 3, 10, 0);
    steady = 1'b0;
    // back to safe so the long warning stretch below starts from the first level
    send_poll(1, 16'd0, 1);
    wait_idle();

    // every reading is warning; the beep only comes after the longest delay
    configure(16'd0, 16'hFFFF, 8'hFF, 8'hFF, 5'd16);
    run_phase(270, 0, 10, 1);

    configure(16'hFFFF, 16'd0, 8'd0, 8'd0, 5'd0);
    run_phase(30, 10, 20, 0);

    configure(RST_WARN_THRESHOLD, RST_DANGER_THRESHOLD, RST_BEEP_DELAY,
              RST_REPLY_ADDRESS, RST_REPLY_LENGTH);
    run_phase(60, 5, 15, 0);

    if (errors == 0 && results_due.size() == 0) begin
      $display("** gas_level_alarm_controller: PASSED **");
    end else begin
      $display("** gas_level_alarm_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** gas_level_alarm_controller: FAILED **");
    $finish;
  end

endmodule

@@ gas_level_alarm_controller.f @@
hw/rtl/gla_pkg.sv
hw/rtl/gla_cfg_regs.sv
hw/rtl/gla_alarm.sv
hw/rtl/gas_level_alarm_controller.sv
tb/gas_level_alarm_controller_test.sv
